// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL, included by mode_s_message_decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_PROP(lbl, !(cond), msg)

`endif

// ===== rtl/msd_pkg.sv =====
package msd_pkg;

  localparam int MsgHalfW = 56;
  localparam int MsgW     = 2 * MsgHalfW;
  localparam int CrcW     = 24;
  localparam int LongLen  = 88;
  localparam int ShortLen = 32;

  localparam logic [CrcW:0] CrcGenerator = 25'h1FFF409;

  // Downlink formats
  localparam logic [4:0] DfSurvAlt  = 5'd4;
  localparam logic [4:0] DfSurvId   = 5'd5;
  localparam logic [4:0] DfAllCall  = 5'd11;
  localparam logic [4:0] DfLongLo   = 5'd16;
  localparam logic [4:0] DfExtSq    = 5'd17;
  localparam logic [4:0] DfExtSqNt  = 5'd18;
  localparam logic [4:0] DfLongHi   = 5'd24;

  // Extended squitter type codes and velocity subtypes
  localparam logic [4:0] TcIdentLo  = 5'd1;
  localparam logic [4:0] TcIdentHi  = 5'd4;
  localparam logic [4:0] TcAirPosLo = 5'd9;
  localparam logic [4:0] TcAirPosHi = 5'd18;
  localparam logic [4:0] TcVelocity = 5'd19;
  localparam logic [2:0] VelSubGnd  = 3'd1;
  localparam logic [2:0] VelSubSup  = 3'd2;

  // found_mask bit positions
  localparam int FoundAlt    = 0;
  localparam int FoundSquawk = 1;
  localparam int FoundIdent  = 2;
  localparam int FoundCpr    = 3;
  localparam int FoundVel    = 4;

  typedef logic [LongLen-1:0][CrcW-1:0] crc_tab_t;

  typedef struct packed {
    logic [4:0]         found;
    logic signed [11:0] alt_base;
    logic               alt_x100;
    logic [11:0]        squawk;
    logic [63:0]        ident;
    logic [34:0]        cpr;
    logic signed [12:0] vel_east;
    logic signed [12:0] vel_north;
  } dec_t;

  // Entry d-1 is the residue contribution of a one bit followed by d-1 bits.
  function automatic crc_tab_t crc_table();
    crc_tab_t      t;
    logic [CrcW:0] r;
    r = {1'b1, {CrcW{1'b0}}} ^ CrcGenerator;
    t[0] = r[CrcW-1:0];
    for (int d = 1; d < LongLen; d++) begin
      r = {r[CrcW-1:0], 1'b0};
      if (r[CrcW]) begin
        r = r ^ CrcGenerator;
      end
      t[d] = r[CrcW-1:0];
    end
    return t;
  endfunction

  localparam crc_tab_t CrcTab = crc_table();

  // {valid, adjust} for the C digit, odd selects the second row
  function automatic logic [3:0] c_digit_lookup(input logic odd, input logic [2:0] d);
    logic [3:0] res;
    unique case ({odd, d})
      4'b0001: res = 4'b1000;
      4'b0010: res = 4'b1010;
      4'b0011: res = 4'b1001;
      4'b0100: res = 4'b1100;
      4'b0110: res = 4'b1011;
      4'b1001: res = 4'b1100;
      4'b1010: res = 4'b1010;
      4'b1011: res = 4'b1011;
      4'b1100: res = 4'b1000;
      4'b1110: res = 4'b1001;
      default: res = 4'b0000;
    endcase
    return res;
  endfunction

  function automatic logic [7:0] ident_char(input logic [5:0] c);
    logic [7:0] ch;
    if (c >= 6'd1 && c <= 6'd26) begin
      ch = 8'h40 + {2'b00, c};
    end else if (c == 6'd32) begin
      ch = 8'h20;
    end else if (c >= 6'd48 && c <= 6'd57) begin
      ch = {2'b00, c};
    end else begin
      ch = 8'h3F;
    end
    return ch;
  endfunction

endpackage

// ===== rtl/msd_if.sv =====
interface msd_in_if import msd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MsgHalfW-1:0] msg_head;
  logic [MsgHalfW-1:0] msg_tail;

  modport source (output valid, msg_head, msg_tail, input ready);
  modport sink (input valid, msg_head, msg_tail, output ready);
endinterface

interface msd_out_if import msd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [4:0]         downlink_format;
  logic [CrcW-1:0]    icao_address;
  logic               address_from_parity;
  logic [4:0]         found_mask;
  logic signed [18:0] altitude_feet;
  logic [11:0]        squawk_octal;
  logic [63:0]        flight_ident;
  logic [34:0]        cpr_frame;
  logic signed [12:0] velocity_east;
  logic signed [12:0] velocity_north;

  modport source (output valid, accepted, downlink_format, icao_address, address_from_parity,
                  found_mask, altitude_feet, squawk_octal, flight_ident, cpr_frame,
                  velocity_east, velocity_north, input ready);
  modport sink (input valid, accepted, downlink_format, icao_address, address_from_parity,
                found_mask, altitude_feet, squawk_octal, flight_ident, cpr_frame,
                velocity_east, velocity_north, output ready);
endinterface

// ===== rtl/mode_s_message_decoder.sv =====
// Mode S downlink message decoder.
// msg_i carries one 112-bit message per item, message bit 0 in msg_head[55].
// res_o carries one result item per message: parity verdict, format, address
// and the decoded altitude, squawk, identity, CPR words and ground velocity.
// Both channels move an item on a clock edge where valid and ready are high.
// Pipeline: a message accepted on msg_i passes the parity partial sums,
// then residue and field decode, then altitude scaling into the output
// register, from which its result item shows on res_o.valid.
// Throughput: one item per cycle while res_o.ready is high; each of the three stages holds one item.
// When the receiver stalls, the output register holds and stages behind it
// keep filling until all three are full; msg_i.ready then drops, and rises
// again in the cycle the output item is taken. Nothing is lost or repeated.
// A rejected message (formats 11, 17 or 18 with a bad parity) gives
// accepted low, its format, and zeros everywhere else.
// Reset clears all stage valid bits; no item is pending after reset.
`include "assert_macros.svh"
module mode_s_message_decoder import msd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  msd_in_if.sink     msg_i,
  msd_out_if.source  res_o
);

  logic [MsgW-1:0] in_msg;
  logic            rdy1, rdy2, rdy3;

  // stage 1
  logic            v1_q;
  logic [MsgW-1:0] msg1_q;
  logic [CrcW-1:0] crc_la_d, crc_la_q, crc_lb_d, crc_lb_q, crc_s_d, crc_s_q;

  // stage 2
  logic            v2_q;
  logic            acc_d, acc_q;
  logic [4:0]      fmt1, fmt2_q;
  logic [CrcW-1:0] addr_d, addr_q;
  logic            afp_d, afp_q;
  logic            long1;
  logic [CrcW-1:0] resid, par;
  dec_t            dec_d, dec_q;

  // stage 3
  logic               v3_q;
  logic [6:0]         alt_scale;
  logic signed [19:0] alt_prod;

  assign in_msg = {msg_i.msg_head, msg_i.msg_tail};

  // Ready runs back from the output; a stage moves when its successor has room.
  assign rdy3        = !v3_q || res_o.ready;
  assign rdy2        = !v2_q || rdy3;
  assign rdy1        = !v1_q || rdy2;
  assign msg_i.ready = rdy1;

  // Residue is linear in the message bits: XOR the precomputed contributions.
  always_comb begin
    crc_la_d = '0;
    crc_lb_d = '0;
    crc_s_d  = '0;
    for (int i = 0; i < LongLen / 2; i++) begin
      if (in_msg[MsgW-1-i]) begin
        crc_la_d = crc_la_d ^ CrcTab[LongLen-1-i];
      end
    end
    for (int i = LongLen / 2; i < LongLen; i++) begin
      if (in_msg[MsgW-1-i]) begin
        crc_lb_d = crc_lb_d ^ CrcTab[LongLen-1-i];
      end
    end
    for (int i = 0; i < ShortLen; i++) begin
      if (in_msg[MsgW-1-i]) begin
        crc_s_d = crc_s_d ^ CrcTab[ShortLen-1-i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= msg_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && msg_i.valid) begin
      msg1_q   <= in_msg;
      crc_la_q <= crc_la_d;
      crc_lb_q <= crc_lb_d;
      crc_s_q  <= crc_s_d;
    end
  end

  // Stage 2: finish the residue, check parity, decode the fields.
  assign fmt1  = msg1_q[111:107];
  assign long1 = fmt1 >= DfLongLo && fmt1 <= DfLongHi;
  assign resid = long1 ? (crc_la_q ^ crc_lb_q) : crc_s_q;
  assign par   = long1 ? msg1_q[23:0] : msg1_q[79:56];

  always_comb begin
    if (fmt1 == DfAllCall || fmt1 == DfExtSq || fmt1 == DfExtSqNt) begin
      acc_d  = (resid == par);
      addr_d = msg1_q[103:80];
      afp_d  = 1'b0;
    end else begin
      acc_d  = 1'b1;
      addr_d = resid ^ par;
      afp_d  = 1'b1;
    end
  end

  msd_decode u_decode (
    .msg_i (msg1_q),
    .dec_o (dec_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      acc_q  <= acc_d;
      fmt2_q <= fmt1;
      addr_q <= addr_d;
      afp_q  <= afp_d;
      dec_q  <= dec_d;
    end
  end

  // Stage 3: scale altitude, drop the fields of a rejected message.
  assign alt_scale = dec_q.alt_x100 ? 7'd100 : 7'd25;
  assign alt_prod  = 20'(dec_q.alt_base) * signed'({13'd0, alt_scale});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      res_o.accepted        <= acc_q;
      res_o.downlink_format <= fmt2_q;
      if (acc_q) begin
        res_o.icao_address        <= addr_q;
        res_o.address_from_parity <= afp_q;
        res_o.found_mask          <= dec_q.found;
        res_o.altitude_feet       <= alt_prod[18:0];
        res_o.squawk_octal        <= dec_q.squawk;
        res_o.flight_ident        <= dec_q.ident;
        res_o.cpr_frame           <= dec_q.cpr;
        res_o.velocity_east       <= dec_q.vel_east;
        res_o.velocity_north      <= dec_q.vel_north;
      end else begin
        res_o.icao_address        <= '0;
        res_o.address_from_parity <= 1'b0;
        res_o.found_mask          <= '0;
        res_o.altitude_feet       <= '0;
        res_o.squawk_octal        <= '0;
        res_o.flight_ident        <= '0;
        res_o.cpr_frame           <= '0;
        res_o.velocity_east       <= '0;
        res_o.velocity_north      <= '0;
      end
    end
  end

  assign res_o.valid = v3_q;

  `ASSERT_PROP(a_reject_clear, res_o.valid && !res_o.accepted |-> res_o.found_mask == '0 && res_o.icao_address == '0, "rejected item carries decoded fields")
  `ASSERT_NEVER(a_vel_only_es, res_o.valid && res_o.found_mask[FoundVel] && res_o.downlink_format != DfExtSq, "velocity decoded outside extended squitter")
  `ASSERT_NEVER(a_squawk_only_df5, res_o.valid && res_o.found_mask[FoundSquawk] && res_o.downlink_format != DfSurvId, "squawk decoded outside identity reply")
  `ASSERT_PROP(a_parity_addr, res_o.valid && res_o.accepted |-> res_o.address_from_parity == !(res_o.downlink_format == DfAllCall || res_o.downlink_format == DfExtSq || res_o.downlink_format == DfExtSqNt), "address source does not match format")

endmodule

// ===== rtl/msd_decode.sv =====
module msd_decode import msd_pkg::*; (
  input  logic [MsgW-1:0] msg_i,
  output dec_t            dec_o
);

  logic [4:0]  fmt;
  logic [12:0] ac;
  logic [4:0]  tc;
  logic [2:0]  sub;
  logic [11:0] alt_es;
  logic [9:0]  we;
  logic [9:0]  sn;
  logic [9:0]  we_mag;
  logic [9:0]  sn_mag;
  logic [11:0] we_scl;
  logic [11:0] sn_scl;
  logic [7:0]  dab;
  logic [7:0]  code;
  logic [2:0]  c_dig;
  logic [3:0]  c_adj;
  logic [10:0] code5;

  // Message bit p sits at msg_i[MsgW-1-p].
  assign fmt    = msg_i[111:107];
  assign ac     = msg_i[92:80];
  assign tc     = msg_i[79:75];
  assign sub    = msg_i[74:72];
  assign alt_es = msg_i[71:60];
  assign we     = msg_i[65:56];
  assign sn     = msg_i[54:45];
  assign we_mag = we - 10'd1;
  assign sn_mag = sn - 10'd1;
  assign we_scl = (sub == VelSubSup) ? {we_mag, 2'b00} : {2'b00, we_mag};
  assign sn_scl = (sub == VelSubSup) ? {sn_mag, 2'b00} : {2'b00, sn_mag};

  // Gillham: D2 D4 from bits 0 and 2, A digit, B digit, then Gray to binary
  assign dab   = {ac[2], ac[0], ac[11], ac[9], ac[7], ac[5], ac[3], ac[1]};
  assign code  = dab ^ (dab >> 4) ^ (dab >> 2) ^ (dab >> 1) ^ (dab >> 6) ^ (dab >> 3)
               ^ (dab >> 5) ^ (dab >> 7);
  assign c_dig = {ac[12], ac[10], ac[8]};
  assign c_adj = c_digit_lookup(code[0], c_dig);
  assign code5 = {1'b0, code, 2'b00} + {3'b000, code};

  always_comb begin
    dec_o = '0;
    unique case (fmt)
      DfExtSq: begin
        if (tc >= TcIdentLo && tc <= TcIdentHi) begin
          for (int i = 0; i < 8; i++) begin
            dec_o.ident[63-8*i -: 8] = ident_char(msg_i[71-6*i -: 6]);
          end
          dec_o.found[FoundIdent] = 1'b1;
        end
        if (tc >= TcAirPosLo && tc <= TcAirPosHi) begin
          if (alt_es[4]) begin
            dec_o.alt_base       = signed'({1'b0, alt_es[11:5], alt_es[3:0]}) - 12'sd40;
            dec_o.found[FoundAlt] = 1'b1;
          end
          dec_o.cpr             = msg_i[58:24];
          dec_o.found[FoundCpr] = 1'b1;
        end else if (tc == TcVelocity && (sub == VelSubGnd || sub == VelSubSup)
                     && we != '0 && sn != '0) begin
          dec_o.vel_east        = msg_i[66] ? -signed'({1'b0, we_scl})
                                            : signed'({1'b0, we_scl});
          dec_o.vel_north       = msg_i[55] ? -signed'({1'b0, sn_scl})
                                            : signed'({1'b0, sn_scl});
          dec_o.found[FoundVel] = 1'b1;
        end
      end
      DfSurvAlt: begin
        if (!ac[6]) begin
          if (ac[4]) begin
            dec_o.alt_base        = signed'({1'b0, ac[12:7], ac[5], ac[3:0]}) - 12'sd40;
            dec_o.found[FoundAlt] = 1'b1;
          end else if (c_adj[3]) begin
            dec_o.alt_base        = signed'({1'b0, code5}) - 12'sd12
                                  + signed'({9'd0, c_adj[2:0]});
            dec_o.alt_x100        = 1'b1;
            dec_o.found[FoundAlt] = 1'b1;
          end
        end
      end
      DfSurvId: begin
        dec_o.squawk = {ac[7], ac[9], ac[11], ac[1], ac[3], ac[5],
                        ac[8], ac[10], ac[12], ac[0], ac[2], ac[4]};
        dec_o.found[FoundSquawk] = 1'b1;
      end
      default: dec_o = '0;
    endcase
  end

endmodule

// ===== verif/mode_s_message_decoder_tb.sv =====
`timescale 1ns / 1ps

module mode_s_message_decoder_tb;
  import msd_pkg::*;

  localparam logic [4:0] DfAcasShort    = 5'd0;
  localparam logic [4:0] TcNoPos        = 5'd0;
  localparam logic [2:0] VelSubAirspeed = 3'd3;
  localparam int         WatchdogLimit  = 2000;
  localparam int         ItemsPerPhase  = 163;
  localparam int         DrainCycles    = 8;

  // sender idle and receiver stall odds, in percent, for each phase
  localparam int IdlePct  [4] = '{0, 81, 0, 36};
  localparam int StallPct [4] = '{0, 0, 81, 36};

  // C digit adjustment, row picked by the low bit of the decoded Gray code
  localparam int CAdjust [2][8] = '{'{-1, 0, 2, 1, 4, -1, 3, -1},
                                    '{-1, 4, 2, 3, 0, -1, 1, -1}};

  typedef struct packed {
    logic               accepted;
    logic [4:0]         fmt;
    logic [23:0]        icao;
    logic               afp;
    logic [4:0]         found;
    logic signed [18:0] alt;
    logic [11:0]        squawk;
    logic [63:0]        ident;
    logic [34:0]        cpr;
    logic signed [12:0] vel_e;
    logic signed [12:0] vel_n;
  } result_t;

  typedef struct {
    logic [MsgW-1:0] msg;
    bit              seal;
    bit              typed;
    result_t         want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic rx_ready = 1'b0;

  int idle_pct  = 0;
  int stall_pct = 0;
  int errors    = 0;
  int n_sent    = 0;
  int n_results = 0;
  int n_reject  = 0;
  int n_found [5] = '{0, 0, 0, 0, 0};
  int quiet_cycles = 0;

  result_t  pending_results [$];
  dir_row_t directed_msgs [$];

  msd_in_if  msg_if ();
  msd_out_if res_if ();

  assign res_if.ready = rx_ready;

  mode_s_message_decoder u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .msg_i  (msg_if),
    .res_o  (res_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic bit long_format(input logic [4:0] fmt);
    return fmt >= DfLongLo && fmt <= DfLongHi;
  endfunction

  // message bit 0 enters first; it sits at index MsgW-1
  function automatic logic [23:0] parity_residue(input logic [MsgW-1:0] m, input int len);
    logic [24:0] r;
    r = '0;
    for (int i = 0; i < len; i++) begin
      r[23] = r[23] ^ m[MsgW-1-i];
      r = r << 1;
      if (r[24]) begin
        r = r ^ CrcGenerator;
      end
    end
    return r[23:0];
  endfunction

  function automatic logic [MsgW-1:0] with_parity(input logic [MsgW-1:0] m);
    logic [MsgW-1:0] s;
    s = m;
    if (long_format(m[111:107])) begin
      s[23:0] = parity_residue(m, LongLen);
    end else begin
      s[79:56] = parity_residue(m, ShortLen);
    end
    return s;
  endfunction

  function automatic logic [7:0] ident_ascii(input logic [5:0] c);
    logic [7:0] ch;
    if (c >= 6'd1 && c <= 6'd26) begin
      ch = "A" + {2'b00, c} - 8'd1;
    end else if (c == 6'd32) begin
      ch = " ";
    end else if (c >= 6'd48 && c <= 6'd57) begin
      ch = {2'b00, c};
    end else begin
      ch = "?";
    end
    return ch;
  endfunction

  function automatic result_t bare_result(input logic acc, input logic [4:0] fmt,
                                          input logic afp);
    result_t res;
    res = '0;
    res.accepted = acc;
    res.fmt = fmt;
    res.afp = afp;
    return res;
  endfunction

  function automatic result_t decode_message(input logic [MsgW-1:0] m);
    result_t     res;
    logic [4:0]  fmt;
    logic [4:0]  tc;
    logic [2:0]  sub;
    logic [23:0] pf;
    logic [23:0] rem;
    logic [12:0] ac;
    logic [11:0] a;
    logic [9:0]  we;
    logic [9:0]  sn;
    logic [7:0]  dab;
    logic [7:0]  code;
    logic [2:0]  cd;
    int          n;
    int          alt;
    int          ve;
    int          vn;
    int          adj;
    res = '0;
    alt = 0;
    fmt = m[111:107];
    pf  = long_format(fmt) ? m[23:0] : m[79:56];
    rem = parity_residue(m, long_format(fmt) ? LongLen : ShortLen);
    ac  = m[92:80];
    res.fmt = fmt;
    if (fmt == DfAllCall || fmt == DfExtSq || fmt == DfExtSqNt) begin
      if (rem != pf) begin
        return res;
      end
      res.icao = m[103:80];
    end else begin
      res.icao = rem ^ pf;
      res.afp = 1'b1;
    end
    res.accepted = 1'b1;

    if (fmt == DfExtSq) begin
      tc = m[79:75];
      if (tc >= TcIdentLo && tc <= TcIdentHi) begin
        for (int i = 0; i < 8; i++) begin
          res.ident = {res.ident[55:0], ident_ascii(m[71-6*i -: 6])};
        end
        res.found[FoundIdent] = 1'b1;
      end
      if (tc >= TcAirPosLo && tc <= TcAirPosHi) begin
        a = m[71:60];
        if (a[4]) begin
          n = int'({a[11:5], a[3:0]});
          alt = n * 25 - 1000;
          res.found[FoundAlt] = 1'b1;
        end
        res.cpr = m[58:24];
        res.found[FoundCpr] = 1'b1;
      end else if (tc == TcVelocity) begin
        sub = m[74:72];
        we  = m[65:56];
        sn  = m[54:45];
        if ((sub == VelSubGnd || sub == VelSubSup) && we != 0 && sn != 0) begin
          ve = int'(we) - 1;
          vn = int'(sn) - 1;
          if (m[66]) begin
            ve = -ve;
          end
          if (m[55]) begin
            vn = -vn;
          end
          if (sub == VelSubSup) begin
            ve = ve * 4;
            vn = vn * 4;
          end
          res.vel_e = ve[12:0];
          res.vel_n = vn[12:0];
          res.found[FoundVel] = 1'b1;
        end
      end
    end else if (fmt == DfSurvAlt) begin
      if (!ac[6]) begin
        if (ac[4]) begin
          n = int'({ac[12:7], ac[5], ac[3:0]});
          alt = n * 25 - 1000;
          res.found[FoundAlt] = 1'b1;
        end else begin
          dab = {ac[2], ac[0], ac[11], ac[9], ac[7], ac[5], ac[3], ac[1]};
          // Gray to binary: running XOR from the top bit down
          code[7] = dab[7];
          for (int i = 6; i >= 0; i--) begin
            code[i] = code[i+1] ^ dab[i];
          end
          cd  = {ac[12], ac[10], ac[8]};
          adj = CAdjust[code[0]][cd];
          if (adj >= 0) begin
            alt = (int'(code) * 5 - 12 + adj) * 100;
            res.found[FoundAlt] = 1'b1;
          end
        end
      end
    end else if (fmt == DfSurvId) begin
      res.squawk = {ac[7], ac[9], ac[11], ac[1], ac[3], ac[5],
                    ac[8], ac[10], ac[12], ac[0], ac[2], ac[4]};
      res.found[FoundSquawk] = 1'b1;
    end
    res.alt = alt[18:0];
    return res;
  endfunction

  function automatic logic [MsgW-1:0] random_message();
    logic [MsgW-1:0] m;
    int              kind;
    int              pick;
    int              p;
    m[111:80] = $urandom();
    m[79:48]  = $urandom();
    m[47:16]  = $urandom();
    m[15:0]   = 16'($urandom_range(16'hFFFF));
    kind = $urandom_range(99);
    if (kind < 40) begin
      m[111:107] = DfExtSq;
      pick = $urandom_range(9);
      if (pick < 3) begin
        m[79:75] = 5'($urandom_range(TcIdentHi, TcIdentLo));
      end else if (pick < 6) begin
        m[79:75] = 5'($urandom_range(TcAirPosHi, TcAirPosLo));
      end else if (pick < 9) begin
        m[79:75] = TcVelocity;
        if ($urandom_range(7) != 0) begin
          m[74:72] = 3'($urandom_range(VelSubSup, VelSubGnd));
        end
      end
      m = with_parity(m);
    end else if (kind < 52) begin
      m[111:107] = DfSurvAlt;
      if ($urandom_range(3) != 0) begin
        m[86] = 1'b0;
      end
    end else if (kind < 62) begin
      m[111:107] = DfSurvId;
    end else if (kind < 70) begin
      m[111:107] = DfAllCall;
      m = with_parity(m);
    end else if (kind < 76) begin
      m[111:107] = DfExtSqNt;
      m = with_parity(m);
    end else if (kind >= 88) begin
      // seal, then flip one covered bit past the format field
      case ($urandom_range(2))
        0: m[111:107] = DfAllCall;
        1: m[111:107] = DfExtSq;
        default: m[111:107] = DfExtSqNt;
      endcase
      m = with_parity(m);
      p = $urandom_range(long_format(m[111:107]) ? 111 : 55, 5);
      m[MsgW-1-p] = ~m[MsgW-1-p];
    end
    return m;
  endfunction

  task automatic add_row(input logic [MsgW-1:0] msg, input bit seal, input bit typed,
                         input result_t want);
    dir_row_t r;
    r.msg   = msg;
    r.seal  = seal;
    r.typed = typed;
    r.want  = want;
    directed_msgs.push_back(r);
  endtask

  // hold the item until the handshake completes, then queue its result
  task automatic send_message(input logic [MsgW-1:0] m, input result_t want);
    while ($urandom_range(99) < idle_pct) begin
      msg_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    msg_if.valid    <= 1'b1;
    msg_if.msg_head <= m[111:56];
    msg_if.msg_tail <= m[55:0];
    @(posedge clk_i);
    while (!msg_if.ready) begin
      @(posedge clk_i);
    end
    pending_results.push_back(want);
    n_sent++;
  endtask

  task automatic cmp_field(input string name, input logic [63:0] want,
                           input logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (!rst_ni) begin
      rx_ready <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      rx_ready <= ($urandom_range(99) >= stall_pct);
      if (res_if.valid && rx_ready) begin
        n_results++;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t ns: result item with nothing expected, format %0d",
                   $time, res_if.downlink_format);
        end else begin
          want = pending_results.pop_front();
          cmp_field("accepted", want.accepted, res_if.accepted);
          cmp_field("downlink_format", want.fmt, res_if.downlink_format);
          cmp_field("icao_address", want.icao, res_if.icao_address);
          cmp_field("address_from_parity", want.afp, res_if.address_from_parity);
          cmp_field("found_mask", want.found, res_if.found_mask);
          cmp_field("altitude_feet", want.alt, res_if.altitude_feet);
          cmp_field("squawk_octal", want.squawk, res_if.squawk_octal);
          cmp_field("flight_ident", want.ident, res_if.flight_ident);
          cmp_field("cpr_frame", want.cpr, res_if.cpr_frame);
          cmp_field("velocity_east", want.vel_e, res_if.velocity_east);
          cmp_field("velocity_north", want.vel_n, res_if.velocity_north);
          if (!want.accepted) begin
            n_reject++;
          end
          for (int b = 0; b < 5; b++) begin
            if (want.found[b]) begin
              n_found[b]++;
            end
          end
        end
      end
      if ((msg_if.valid && msg_if.ready) || (res_if.valid && rx_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: no item moved for %0d cycles", WatchdogLimit);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    logic [MsgW-1:0] m;
    result_t         want;
    msg_if.valid    = 1'b0;
    msg_if.msg_head = '0;
    msg_if.msg_tail = '0;
    rst_ni = 1'b0;

    add_row('0, 1'b0, 1'b1, bare_result(1'b1, DfAcasShort, 1'b1));
    add_row({DfAllCall, 107'h0}, 1'b0, 1'b1, bare_result(1'b0, DfAllCall, 1'b0));
    add_row({DfExtSq, 107'h0}, 1'b0, 1'b1, bare_result(1'b0, DfExtSq, 1'b0));
    add_row({DfExtSqNt, 107'h0}, 1'b0, 1'b1, bare_result(1'b0, DfExtSqNt, 1'b0));
    add_row({MsgW{1'b1}}, 1'b0, 1'b0, '0);
    add_row({DfAllCall, 3'd7, 24'hFFFFFF, 24'h0, 56'hFF_FFFF_FFFF_FFFF}, 1'b1, 1'b0, '0);
    add_row({DfExtSq, 3'd5, 24'hABCDEF, TcIdentLo, 3'd0, 6'd0, 6'd1, 6'd26, 6'd27,
             6'd32, 6'd48, 6'd57, 6'd63, 24'h0}, 1'b1, 1'b0, '0);
    add_row({DfExtSq, 3'd0, 24'h000001, TcIdentHi, 3'd7, 6'd2, 6'd15, 6'd25, 6'd31,
             6'd33, 6'd47, 6'd58, 6'd47, 24'h0}, 1'b1, 1'b0, '0);
    add_row({DfExtSq, 3'd5, 24'h4840D6, TcAirPosLo, 3'd0, 12'hFFF, 1'b0, 1'b1,
             17'h1FFFF, 17'h1FFFF, 24'h0}, 1'b1, 1'b0, '0);
    add_row({DfExtSq, 3'd5, 24'h4840D6, TcAirPosHi, 3'd7, 12'hFEF, 1'b1, 1'b0,
             17'h0, 17'h0, 24'h0}, 1'b1, 1'b0, '0);
    add_row({DfExtSq, 3'd5, 24'h40621D, TcAirPosLo + 5'd2, 3'd0, 12'h010, 1'b0, 1'b1,
             17'h0AAAA, 17'h15555, 24'h0}, 1'b1, 1'b0, '0);
    add_row({DfExtSq, 3'd5, 24'h123456, TcVelocity, VelSubGnd, 5'd0, 1'b1, 10'h3FF,
             1'b1, 10'h3FF, 21'h0, 24'h0}, 1'b1, 1'b0, '0);
    add_row({DfExtSq, 3'd5, 24'h123456, TcVelocity, VelSubSup, 5'h1F, 1'b0, 10'h3FF,
             1'b0, 10'h3FF, 21'h1FFFFF, 24'h0}, 1'b1, 1'b0, '0);
    add_row({DfExtSq, 3'd5, 24'h123456, TcVelocity, VelSubGnd, 5'd0, 1'b0, 10'h0,
             1'b0, 10'd5, 21'h0, 24'h0}, 1'b1, 1'b0, '0);
    add_row({DfExtSq, 3'd5, 24'h123456, TcVelocity, VelSubSup, 5'd0, 1'b1, 10'd1,
             1'b1, 10'd1, 21'h0, 24'h0}, 1'b1, 1'b0, '0);
    add_row({DfExtSq, 3'd5, 24'h123456, TcVelocity, VelSubAirspeed, 5'd0, 1'b0, 10'd100,
             1'b0, 10'd200, 21'h0, 24'h0}, 1'b1, 1'b0, '0);
    add_row({DfExtSq, 3'd5, 24'hC0FFEE, TcNoPos, 51'h7_FFFF_FFFF_FFFF, 24'h0},
            1'b1, 1'b0, '0);
    add_row({DfSurvAlt, 14'h0, 13'h1FBF, 24'h0, 56'h0}, 1'b0, 1'b0, '0);
    add_row({DfSurvAlt, 14'h0, 13'h0104, 24'h0, 56'h0}, 1'b0, 1'b0, '0);
    add_row({DfSurvAlt, 14'h0, 13'h0100, 24'h0, 56'h0}, 1'b0, 1'b0, '0);
    add_row({DfSurvAlt, 14'h3FFF, 13'h0000, 24'hFFFFFF, 56'h0}, 1'b0, 1'b0, '0);
    add_row({DfSurvId, 14'h3FFF, 13'h1FFF, 24'hFFFFFF, 56'h0}, 1'b0, 1'b0, '0);
    add_row({DfLongLo, {13{8'hA5}}, 3'b101}, 1'b0, 1'b0, '0);
    add_row({DfLongHi, {13{8'h5A}}, 3'b010}, 1'b0, 1'b0, '0);
    add_row({DfLongLo - 5'd1, {13{8'h3C}}, 3'b110}, 1'b0, 1'b0, '0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_msgs[i]) begin
      m = directed_msgs[i].seal ? with_parity(directed_msgs[i].msg) : directed_msgs[i].msg;
      want = directed_msgs[i].typed ? directed_msgs[i].want : decode_message(m);
      send_message(m, want);
    end

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = IdlePct[ph];
      stall_pct = StallPct[ph];
      repeat (ItemsPerPhase) begin
        m = random_message();
        send_message(m, decode_message(m));
      end
    end
    msg_if.valid <= 1'b0;

    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d messages decoded, %0d rejected on parity; altitude %0d, squawk %0d,",
             n_results, n_reject, n_found[FoundAlt], n_found[FoundSquawk]);
    $display("identity %0d, CPR words %0d, ground velocity %0d, under four idle/stall mixes",
             n_found[FoundIdent], n_found[FoundCpr], n_found[FoundVel]);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/msd_pkg.sv
rtl/msd_if.sv
rtl/msd_decode.sv
rtl/mode_s_message_decoder.sv
verif/mode_s_message_decoder_tb.sv
